@@ rtl/core/sbe_pkg.sv @@
package sbe_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int SP_W        = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int DATA_W      = 32;
    localparam int STEP_W      = $clog2(DATA_W);
    localparam int OP_W        = 3;
    localparam int ST_W        = 2;

    localparam logic [OP_W-1:0] OP_PUSH   = 3'd0;
    localparam logic [OP_W-1:0] OP_ADD    = 3'd1;
    localparam logic [OP_W-1:0] OP_SUB    = 3'd2;
    localparam logic [OP_W-1:0] OP_MUL    = 3'd3;
    localparam logic [OP_W-1:0] OP_DIV    = 3'd4;
    localparam logic [OP_W-1:0] OP_MOD    = 3'd5;
    localparam logic [OP_W-1:0] OP_FINISH = 3'd6;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_UNDER = 2'd1;
    localparam logic [ST_W-1:0] ST_OVER  = 2'd2;
    localparam logic [ST_W-1:0] ST_DIVZ  = 2'd3;

    typedef struct packed {
        logic            we;
        logic [SP_W-1:0] waddr;
        logic            re;
        logic [SP_W-1:0] raddr;
    } t_stk_ctl;

    typedef struct packed {
        logic            start;
        logic [OP_W-1:0] op;
    } t_alu_req;

endpackage

@@ rtl/core/sbe_stack.sv @@
module sbe_stack (
    input  logic                  i_clk,
    input  sbe_pkg::t_stk_ctl     i_ctl,
    input  logic [sbe_pkg::DATA_W-1:0] i_wdata,
    output logic [sbe_pkg::DATA_W-1:0] o_rdata
);
    import sbe_pkg::*;

    logic [DATA_W-1:0] r_mem [STACK_DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_mem[i_ctl.waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.re) begin
            r_rdata <= r_mem[i_ctl.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/sbe_alu.sv @@
module sbe_alu (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  sbe_pkg::t_alu_req          i_req,
    input  logic [sbe_pkg::DATA_W-1:0] i_a,
    input  logic [sbe_pkg::DATA_W-1:0] i_b,
    output logic                       o_done,
    output logic [sbe_pkg::DATA_W-1:0] o_result
);
    import sbe_pkg::*;

    typedef enum logic [1:0] {A_IDLE, A_RUN, A_FIX} t_alu_state;

    t_alu_state        r_state, n_state;
    logic [OP_W-1:0]   r_op, n_op;
    logic [STEP_W-1:0] r_cnt, n_cnt;
    logic [DATA_W-1:0] r_x, n_x;
    logic [DATA_W-1:0] r_y, n_y;
    logic [DATA_W-1:0] r_d, n_d;
    logic [DATA_W-1:0] r_rem, n_rem;
    logic [DATA_W-1:0] r_res, n_res;
    logic              r_c, n_c;
    logic              r_qneg, n_qneg;
    logic              r_rneg, n_rneg;
    logic              r_done, n_done;

    logic [1:0]        bit_sum;
    logic [DATA_W:0]   dv_shift;
    logic [DATA_W+1:0] dv_trial;
    logic [DATA_W-1:0] abs_a;
    logic [DATA_W-1:0] abs_b;

    assign abs_a    = i_a[DATA_W-1] ? (~i_a + DATA_W'(1)) : i_a;
    assign abs_b    = i_b[DATA_W-1] ? (~i_b + DATA_W'(1)) : i_b;
    assign bit_sum  = {1'b0, r_x[0]} + {1'b0, r_y[0]} + {1'b0, r_c};
    assign dv_shift = {r_rem, r_x[DATA_W-1]};
    assign dv_trial = {1'b0, dv_shift} - {2'b00, r_d};

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_cnt   = r_cnt;
        n_x     = r_x;
        n_y     = r_y;
        n_d     = r_d;
        n_rem   = r_rem;
        n_res   = r_res;
        n_c     = r_c;
        n_qneg  = r_qneg;
        n_rneg  = r_rneg;
        n_done  = 1'b0;
        case (r_state)
            A_IDLE: begin
                if (i_req.start) begin
                    n_state = A_RUN;
                    n_op    = i_req.op;
                    n_cnt   = '0;
                    n_x     = i_a;
                    n_y     = i_b;
                    n_c     = 1'b0;
                    n_res   = '0;
                    n_rem   = '0;
                    n_d     = abs_b;
                    n_qneg  = i_a[DATA_W-1] ^ i_b[DATA_W-1];
                    n_rneg  = i_a[DATA_W-1];
                    case (i_req.op)
                        OP_SUB: begin
                            n_y = ~i_b;
                            n_c = 1'b1;
                        end
                        OP_DIV, OP_MOD: begin
                            n_x = abs_a;
                            n_y = '0;
                        end
                        default: ;
                    endcase
                end
            end
            A_RUN: begin
                n_cnt = r_cnt + STEP_W'(1);
                case (r_op)
                    OP_ADD, OP_SUB: begin
                        // one sum bit per cycle, lsb first
                        n_res = {bit_sum[0], r_res[DATA_W-1:1]};
                        n_c   = bit_sum[1];
                        n_x   = {1'b0, r_x[DATA_W-1:1]};
                        n_y   = {1'b0, r_y[DATA_W-1:1]};
                    end
                    OP_MUL: begin
                        n_res = r_y[0] ? (r_res + r_x) : r_res;
                        n_x   = {r_x[DATA_W-2:0], 1'b0};
                        n_y   = {1'b0, r_y[DATA_W-1:1]};
                    end
                    OP_DIV, OP_MOD: begin
                        // restoring step, one quotient bit per cycle
                        if (!dv_trial[DATA_W+1]) begin
                            n_rem = dv_trial[DATA_W-1:0];
                        end else begin
                            n_rem = dv_shift[DATA_W-1:0];
                        end
                        n_y = {r_y[DATA_W-2:0], ~dv_trial[DATA_W+1]};
                        n_x = {r_x[DATA_W-2:0], 1'b0};
                    end
                    default: ;
                endcase
                if (r_cnt == STEP_W'(DATA_W - 1)) begin
                    n_state = A_FIX;
                end
            end
            A_FIX: begin
                // sign fixup of quotient and remainder
                case (r_op)
                    OP_DIV:  n_res = r_qneg ? (~r_y + DATA_W'(1)) : r_y;
                    OP_MOD:  n_res = r_rneg ? (~r_rem + DATA_W'(1)) : r_rem;
                    default: ;
                endcase
                n_done  = 1'b1;
                n_state = A_IDLE;
            end
            default: n_state = A_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= A_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_op   <= n_op;
        r_cnt  <= n_cnt;
        r_x    <= n_x;
        r_y    <= n_y;
        r_d    <= n_d;
        r_rem  <= n_rem;
        r_res  <= n_res;
        r_c    <= n_c;
        r_qneg <= n_qneg;
        r_rneg <= n_rneg;
    end

    assign o_done   = r_done;
    assign o_result = r_res;

endmodule

@@ rtl/core/stack_bytecode_executor.sv @@
// channel   dir  tdata                  tuser
// s (in)    in   [31:0] push_value      [2:0] opcode
// m (out)   out  [31:0] top_value      [1:0] status
//
// push is written on accept; finish waits for the output register to be free.
// arithmetic goes through accept, two stack reads, 32 bit-serial steps in the
// alu, a sign fixup, the done flag and write-back; add/sub go one bit per
// cycle, mul and div/mod one multiplier or quotient bit per cycle.
// i_rst_n is synchronous; it empties the stack and clears the error.
// a result waits in the output register while the next words are taken.
module stack_bytecode_executor (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    input  logic [sbe_pkg::DATA_W-1:0]  i_s_tdata,   // [31:0] push_value
    input  logic [sbe_pkg::OP_W-1:0]    i_s_tuser,   // [2:0] opcode
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    output logic [sbe_pkg::DATA_W-1:0]  o_m_tdata,   // [31:0] top_value
    output logic [sbe_pkg::ST_W-1:0]    o_m_tuser    // [1:0] status
);
    import sbe_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_RDB, S_RDA, S_ALU, S_FIN} t_state;

    t_state            r_state, n_state;
    logic [OP_W-1:0]   r_op, n_op;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [ST_W-1:0]   r_err, n_err;
    logic [DATA_W-1:0] r_b, n_b;
    logic              r_m_valid, n_m_valid;
    logic [DATA_W-1:0] r_m_data, n_m_data;
    logic [ST_W-1:0]   r_m_user, n_m_user;

    t_stk_ctl          stk_ctl;
    logic [DATA_W-1:0] stk_wdata;
    logic [DATA_W-1:0] stk_rdata;
    t_alu_req          alu_req;
    logic              alu_done;
    logic [DATA_W-1:0] alu_result;

    logic              accept;
    logic [CNT_W-1:0]  cnt_m1;
    logic [CNT_W-1:0]  cnt_m2;

    assign o_s_tready = (r_state == S_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;
    assign cnt_m1     = r_cnt - CNT_W'(1);
    assign cnt_m2     = r_cnt - CNT_W'(2);

    sbe_stack u_stack (
        .i_clk   (i_clk),
        .i_ctl   (stk_ctl),
        .i_wdata (stk_wdata),
        .o_rdata (stk_rdata)
    );

    sbe_alu u_alu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (alu_req),
        .i_a      (stk_rdata),
        .i_b      (r_b),
        .o_done   (alu_done),
        .o_result (alu_result)
    );

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_cnt     = r_cnt;
        n_err     = r_err;
        n_b       = r_b;
        n_m_valid = r_m_valid;
        n_m_data  = r_m_data;
        n_m_user  = r_m_user;
        stk_ctl   = '0;
        stk_wdata = i_s_tdata;
        alu_req   = '0;
        alu_req.op = r_op;

        if (r_m_valid && i_m_tready) begin
            n_m_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_op = i_s_tuser;
                    case (i_s_tuser)
                        OP_PUSH: begin
                            if (r_cnt == CNT_W'(STACK_DEPTH)) begin
                                if (r_err == ST_OK) begin
                                    n_err = ST_OVER;
                                end
                            end else begin
                                stk_ctl.we    = 1'b1;
                                stk_ctl.waddr = r_cnt[SP_W-1:0];
                                n_cnt         = r_cnt + CNT_W'(1);
                            end
                        end
                        OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD: begin
                            if (r_cnt < CNT_W'(2)) begin
                                if (r_err == ST_OK) begin
                                    n_err = ST_UNDER;
                                end
                            end else begin
                                stk_ctl.re    = 1'b1;
                                stk_ctl.raddr = cnt_m1[SP_W-1:0];
                                n_state       = S_RDB;
                            end
                        end
                        OP_FINISH: begin
                            stk_ctl.re    = (r_cnt != '0);
                            stk_ctl.raddr = cnt_m1[SP_W-1:0];
                            n_state       = S_FIN;
                        end
                        default: ;
                    endcase
                end
            end
            S_RDB: begin
                n_b           = stk_rdata;
                stk_ctl.re    = 1'b1;
                stk_ctl.raddr = cnt_m2[SP_W-1:0];
                n_state       = S_RDA;
            end
            S_RDA: begin
                // divide by zero leaves both operands in place
                if ((r_op == OP_DIV || r_op == OP_MOD) && r_b == '0) begin
                    if (r_err == ST_OK) begin
                        n_err = ST_DIVZ;
                    end
                    n_state = S_IDLE;
                end else begin
                    alu_req.start = 1'b1;
                    n_state       = S_ALU;
                end
            end
            S_ALU: begin
                if (alu_done) begin
                    stk_ctl.we    = 1'b1;
                    stk_ctl.waddr = cnt_m2[SP_W-1:0];
                    stk_wdata     = alu_result;
                    n_cnt         = cnt_m1;
                    n_state       = S_IDLE;
                end
            end
            S_FIN: begin
                if (!r_m_valid || i_m_tready) begin
                    n_m_valid = 1'b1;
                    n_m_data  = (r_cnt == '0) ? '0 : stk_rdata;
                    if (r_err != ST_OK) begin
                        n_m_user = r_err;
                    end else if (r_cnt == '0) begin
                        n_m_user = ST_UNDER;
                    end else begin
                        n_m_user = ST_OK;
                    end
                    n_cnt   = '0;
                    n_err   = ST_OK;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_err     <= ST_OK;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_err     <= n_err;
            r_m_valid <= n_m_valid;
        end
        r_op     <= n_op;
        r_b      <= n_b;
        r_m_data <= n_m_data;
        r_m_user <= n_m_user;
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;
    assign o_m_tuser  = r_m_user;

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import sbe_pkg::*;

    localparam int          CLK_HALF    = 4;
    localparam int          CYCLE_LIMIT = 1_000_000;
    localparam int          ITEM_TARGET = 1600;
    localparam int          DRAIN_WAIT  = 64;
    localparam int          MAX_REPORTS = 10;
    localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;
    localparam logic [31:0] INT_MIN     = 32'h8000_0000;
    localparam logic [31:0] INT_MAX     = 32'h7fff_ffff;

    typedef struct packed {
        logic [DATA_W-1:0] top;
        logic [ST_W-1:0]   status;
    } t_finish_word;

    logic              i_clk      = 1'b0;
    logic              i_rst_n    = 1'b0;
    logic              i_s_tvalid = 1'b0;
    logic              o_s_tready;
    logic [DATA_W-1:0] i_s_tdata  = '0;  // [31:0] push_value
    logic [OP_W-1:0]   i_s_tuser  = '0;  // [2:0] opcode
    logic              o_m_tvalid;
    logic              i_m_tready = 1'b0;
    logic [DATA_W-1:0] o_m_tdata;        // [31:0] top_value
    logic [ST_W-1:0]   o_m_tuser;        // [1:0] status

    // shadow machine state
    logic [DATA_W-1:0] shadow_stack [STACK_DEPTH];
    int                shadow_count = 0;
    logic [ST_W-1:0]   shadow_error = ST_OK;
    t_finish_word      pending_finish_q [$];

    int  err_count      = 0;
    int  items_sent     = 0;
    int  results_seen   = 0;
    int  status_seen [4] = '{0, 0, 0, 0};
    int  hold_cycles    = 0;
    int  cycle_cnt      = 0;
    bit  no_idle        = 1'b0;

    stack_bytecode_executor dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("timeout after %0d cycles, %0d results still pending",
                 cycle_cnt, pending_finish_q.size());
        $display("DONE: errors detected");
        $finish;
    end

    function automatic void latch_fault(input logic [ST_W-1:0] code);
        if (shadow_error == ST_OK)
            shadow_error = code;
    endfunction

    // executes one accepted instruction on the shadow stack
    function automatic void execute_instruction(input logic [OP_W-1:0] op,
                                                input logic [DATA_W-1:0] val);
        logic [DATA_W-1:0] lhs, rhs, res;
        longint            slhs, srhs;
        t_finish_word      fw;
        case (op)
            OP_PUSH: begin
                if (shadow_count >= STACK_DEPTH) begin
                    latch_fault(ST_OVER);
                end else begin
                    shadow_stack[shadow_count] = val;
                    shadow_count++;
                end
            end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD: begin
                if (shadow_count < 2) begin
                    latch_fault(ST_UNDER);
                end else begin
                    lhs = shadow_stack[shadow_count-2];
                    rhs = shadow_stack[shadow_count-1];
                    slhs = longint'($signed(lhs));
                    srhs = longint'($signed(rhs));
                    res = '0;
                    case (op)
                        OP_ADD: res = lhs + rhs;
                        OP_SUB: res = lhs - rhs;
                        OP_MUL: res = lhs * rhs;
                        OP_DIV: if (rhs != 0) res = 32'(slhs / srhs);
                        default: if (rhs != 0) res = 32'(slhs % srhs);
                    endcase
                    if ((op == OP_DIV || op == OP_MOD) && rhs == 0) begin
                        latch_fault(ST_DIVZ);
                    end else begin
                        shadow_stack[shadow_count-2] = res;
                        shadow_count--;
                    end
                end
            end
            OP_FINISH: begin
                fw.top = '0;
                if (shadow_count == 0)
                    latch_fault(ST_UNDER);
                else
                    fw.top = shadow_stack[shadow_count-1];
                fw.status = shadow_error;
                pending_finish_q.insert(pending_finish_q.size(), fw);
                shadow_count = 0;
                shadow_error = ST_OK;
            end
            default: ;
        endcase
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (no_idle || roll < 60)
            return 0;
        else if (roll < 93)
            return $urandom_range(1, 3);
        return $urandom_range(15, 50);
    endfunction

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return 32'd1;
            2:       return '1;
            3:       return INT_MIN;
            4:       return INT_MAX;
            5, 6:    return 32'($signed($urandom_range(0, 20)) - 10);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_word(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] val);
        int gap;
        @(negedge i_clk);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= val;
        i_s_tuser  <= op;
        do @(posedge i_clk); while (!o_s_tready);
        execute_instruction(op, val);
        if (op != OP_UNUSED)
            items_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            i_s_tvalid <= 1'b0;
            i_s_tdata  <= $urandom;
            i_s_tuser  <= 3'($urandom);
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic release_input();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
    endtask

    // result side: random stalls plus an occasional long hold-off
    initial begin : result_sink
        int stall_left;
        int roll;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                i_m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_m_tready <= 1'b0;
            end else if (no_idle) begin
                i_m_tready <= 1'b1;
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < 70) begin
                    i_m_tready <= 1'b1;
                end else begin
                    i_m_tready <= 1'b0;
                    stall_left = (roll < 95) ? $urandom_range(0, 2) : $urandom_range(15, 50);
                end
            end
        end
    end

    function automatic void report_fault(input string what, input t_finish_word want);
        err_count++;
        if (err_count <= MAX_REPORTS)
            $display("%s at cycle %0d: expected top=%h status=%0d, got top=%h status=%0d",
                     what, cycle_cnt, want.top, want.status, o_m_tdata, o_m_tuser);
    endfunction

    always @(posedge i_clk) begin
        t_finish_word want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            results_seen++;
            status_seen[o_m_tuser]++;
            if (pending_finish_q.size() == 0) begin
                want = '0;
                report_fault("unexpected word", want);
            end else begin
                want = pending_finish_q.pop_front();
                if (o_m_tdata !== want.top || o_m_tuser !== want.status)
                    report_fault("mismatch", want);
            end
        end
    end

    task automatic test_arith_ops();
        // add wraps to most negative, then divided by minus one
        send_word(OP_PUSH, INT_MAX);
        send_word(OP_PUSH, 32'd1);
        send_word(OP_ADD, $urandom);
        send_word(OP_PUSH, '1);
        send_word(OP_DIV, $urandom);
        send_word(OP_FINISH, $urandom);
        // most negative mod minus one, then sub, mul, signed mod
        send_word(OP_PUSH, INT_MIN);
        send_word(OP_PUSH, '1);
        send_word(OP_MOD, $urandom);
        send_word(OP_PUSH, 32'hffff_fff9);
        send_word(OP_SUB, $urandom);
        send_word(OP_PUSH, 32'd6);
        send_word(OP_MUL, $urandom);
        send_word(OP_PUSH, 32'hffff_fffb);
        send_word(OP_MOD, $urandom);
        send_word(OP_FINISH, $urandom);
        // truncation toward zero
        send_word(OP_PUSH, 32'hffff_fff9);
        send_word(OP_PUSH, 32'd2);
        send_word(OP_DIV, $urandom);
        send_word(OP_FINISH, $urandom);
    endtask

    task automatic test_error_cases();
        send_word(OP_FINISH, $urandom);
        send_word(OP_UNUSED, $urandom);
        // underflow latched first, later divide by zero does not replace it
        send_word(OP_PUSH, 32'd5);
        send_word(OP_ADD, $urandom);
        send_word(OP_PUSH, '0);
        send_word(OP_DIV, $urandom);
        send_word(OP_FINISH, $urandom);
        send_word(OP_PUSH, 32'd9);
        send_word(OP_PUSH, '0);
        send_word(OP_MOD, $urandom);
        send_word(OP_FINISH, $urandom);
    endtask

    task automatic test_stack_overflow();
        for (int i = 0; i <= STACK_DEPTH; i++)
            send_word(OP_PUSH, (i % 2) ? INT_MIN : INT_MAX);
        send_word(OP_SUB, $urandom);
        send_word(OP_FINISH, $urandom);
    endtask

    task automatic test_random_programs(input int target);
        int len;
        int push_pct;
        while (items_sent < target) begin
            no_idle = ($urandom_range(0, 9) == 0);
            if ($urandom_range(0, 9) == 0) begin
                // noise: any opcode in any order
                len = $urandom_range(1, 12);
                repeat (len) send_word(3'($urandom_range(0, 7)), $urandom);
            end else begin
                len = $urandom_range(1, 32);
                push_pct = $urandom_range(30, 85);
                repeat (len) begin
                    if (shadow_count < 2 ||
                        (shadow_count < STACK_DEPTH && $urandom_range(0, 99) < push_pct) ||
                        (shadow_count >= STACK_DEPTH && $urandom_range(0, 19) == 0))
                        send_word(OP_PUSH, pick_value());
                    else
                        send_word(3'($urandom_range(OP_ADD, OP_MOD)), $urandom);
                end
            end
            send_word(OP_FINISH, $urandom);
        end
        no_idle = 1'b0;
    endtask

    task automatic test_output_backpressure();
        no_idle = 1'b1;
        hold_cycles = 300;
        repeat (8) begin
            send_word(OP_PUSH, pick_value());
            send_word(OP_FINISH, $urandom);
        end
        no_idle = 1'b0;
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_arith_ops();
        test_error_cases();
        test_stack_overflow();
        test_random_programs(ITEM_TARGET / 2);
        test_output_backpressure();
        test_random_programs(ITEM_TARGET);
        release_input();

        while (pending_finish_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("ran %0d instructions over %0d cycles, checked %0d finish words",
                 items_sent, cycle_cnt, results_seen);
        $display("status seen: ok %0d, underflow %0d, overflow %0d, div by zero %0d",
                 status_seen[ST_OK], status_seen[ST_UNDER], status_seen[ST_OVER],
                 status_seen[ST_DIVZ]);
        if (err_count == 0 && pending_finish_q.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
